### rtl/core/pfla_pkg.sv
// Package: shared widths, request codes and the shared-unit operand type.
`default_nettype none
package pfla_pkg;

	localparam int unsigned ADDR_W     = 48;
	localparam int unsigned BASE_W     = 36;
	localparam int unsigned CNT_W      = 13;
	localparam int unsigned PAGE_SHIFT = 12;
	localparam int unsigned ALU_W      = BASE_W + 1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// request kinds
	localparam logic [1:0] KIND_INIT  = 2'd0;
	localparam logic [1:0] KIND_ALLOC = 2'd1;
	localparam logic [1:0] KIND_FREE  = 2'd2;
	localparam logic [1:0] KIND_QUERY = 2'd3;

	// configuration register indexes
	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_PAGES = 1'b1;

	typedef struct packed {
		logic              sub;
		logic [BASE_W-1:0] a;
		logic [BASE_W-1:0] b;
	} alu_req_t;

endpackage
`default_nettype wire

### rtl/core/pfla_if.sv
// Interfaces: request and response channels of the page allocator.
`default_nettype none
interface pfla_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic [pfla_pkg::ADDR_W-1:0]  page_address;

	modport source (output valid, kind, page_address, input ready);
	modport sink   (input valid, kind, page_address, output ready);
endinterface

interface pfla_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [pfla_pkg::ADDR_W-1:0]  given_address;
	logic                         success;
	logic [pfla_pkg::CNT_W-1:0]   count;

	modport source (output valid, given_address, success, count, input ready);
	modport sink   (input valid, given_address, success, count, output ready);
endinterface
`default_nettype wire

### rtl/core/pfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pfla_ram #(
	parameter int unsigned WIDTH = 13,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/core/pfla_alu.sv
// Shared add/subtract unit: address forming, region offset and counter sums.
`default_nettype none
module pfla_alu (
	input  wire pfla_pkg::alu_req_t          req,
	output logic [pfla_pkg::ALU_W-1:0]       sum
);

	// top bit is carry on add, borrow on subtract
	always_comb begin
		if (req.sub) begin
			sum = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			sum = {1'b0, req.a} + {1'b0, req.b};
		end
	end

endmodule
`default_nettype wire

### rtl/core/page_free_list_allocator.sv
// Top level: LIFO free-list page allocator with link RAM and a small sequencer.
//
//  channel  dir  handshake            payload
//  req      in   req.valid/req.ready  kind, page_address
//  rsp      out  rsp.valid/rsp.ready  given_address, success, count
//  cfg      in   cfg_write            cfg_index, cfg_data (write only)
//
// From acceptance to result on rsp: query and empty alloc go straight to
// done; alloc pops, free subtracts then checks, init pushes min(pages, MAX_PAGES).
// Init is bound by the single link RAM write port, one page per cycle.
// One item at a time: req.ready is high only while the sequencer is idle;
// the result register lets a new item in while the last result waits.
// Reset clears head, counter and config; the link RAM is not cleared and
// holds nothing meaningful until pages are pushed.
`default_nettype none
module page_free_list_allocator #(
	parameter int unsigned MAX_PAGES = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	pfla_req_if.sink                           req,
	pfla_rsp_if.source                         rsp,
	input  wire logic                          cfg_write,
	input  wire logic                          cfg_index,
	input  wire logic [pfla_pkg::BASE_W-1:0]   cfg_data
);

	// link entries and head hold page offset + 1, zero marks end of list
	localparam int unsigned LW = $clog2(MAX_PAGES + 1);
	localparam int unsigned AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam logic [16:0] MAXP = 17'(MAX_PAGES);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT_WALK,
		S_INIT_SUM,
		S_ALLOC_POP,
		S_FREE_SUB,
		S_FREE_CHK,
		S_DONE
	} state_t;

	state_t                         state_q;
	logic [pfla_pkg::BASE_W-1:0]    base_q;
	logic [pfla_pkg::CNT_W-1:0]     pages_q;
	logic [LW-1:0]                  head_q;
	logic [pfla_pkg::CNT_W-1:0]     total_q;

	logic [pfla_pkg::ADDR_W-1:0]    addr_q;     // address of a pending free
	logic [pfla_pkg::CNT_W-1:0]     n_q;        // pages to push for init
	logic [pfla_pkg::CNT_W-1:0]     idx_q;      // init walk position
	logic [LW-1:0]                  off_q;      // offset of the page being popped
	logic [pfla_pkg::ALU_W-1:0]     diff_q;     // pfn - base, with borrow

	logic [pfla_pkg::ADDR_W-1:0]    res_addr_q;
	logic                           res_ok_q;
	logic [pfla_pkg::CNT_W-1:0]     res_cnt_q;

	logic                           out_valid_q;
	logic [pfla_pkg::ADDR_W-1:0]    out_addr_q;
	logic                           out_ok_q;
	logic [pfla_pkg::CNT_W-1:0]     out_cnt_q;

	logic [pfla_pkg::CNT_W-1:0]     usable;
	logic                           in_fire;
	logic                           free_ok;
	logic [pfla_pkg::CNT_W-1:0]     sat_sum;

	pfla_pkg::alu_req_t             alu_req;
	logic [pfla_pkg::ALU_W-1:0]     alu_sum;

	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic                           ram_re;
	logic [AW-1:0]                  ram_raddr;
	logic [LW-1:0]                  ram_rdata;

	// region clipped to what the link RAM can hold
	assign usable = ({4'b0, pages_q} > MAXP) ? MAXP[pfla_pkg::CNT_W-1:0] : pages_q;

	assign req.ready = (state_q == S_IDLE);
	assign in_fire   = req.valid && req.ready;

	assign rsp.valid         = out_valid_q;
	assign rsp.given_address = out_addr_q;
	assign rsp.success       = out_ok_q;
	assign rsp.count         = out_cnt_q;

	// free accepted: non-zero, page aligned, inside the usable region
	assign free_ok = (addr_q != '0)
		&& (addr_q[pfla_pkg::PAGE_SHIFT-1:0] == '0)
		&& !diff_q[pfla_pkg::ALU_W-1]
		&& (diff_q[pfla_pkg::BASE_W-1:0] < pfla_pkg::BASE_W'(usable));

	// counter sums saturate at the field maximum
	assign sat_sum = (alu_sum[pfla_pkg::ALU_W-1:pfla_pkg::CNT_W] != '0)
		? pfla_pkg::CNT_MAX : alu_sum[pfla_pkg::CNT_W-1:0];

	// operand select for the shared unit
	always_comb begin
		alu_req = '0;
		case (state_q)
			S_ALLOC_POP: begin
				alu_req.a = base_q;
				alu_req.b = pfla_pkg::BASE_W'(off_q);
			end
			S_FREE_SUB: begin
				alu_req.sub = 1'b1;
				alu_req.a   = addr_q[pfla_pkg::ADDR_W-1:pfla_pkg::PAGE_SHIFT];
				alu_req.b   = base_q;
			end
			S_FREE_CHK: begin
				alu_req.a = pfla_pkg::BASE_W'(total_q);
				alu_req.b = pfla_pkg::BASE_W'(1);
			end
			S_INIT_SUM: begin
				alu_req.a = pfla_pkg::BASE_W'(total_q);
				alu_req.b = pfla_pkg::BASE_W'(n_q);
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	pfla_alu u_alu (
		.req (alu_req),
		.sum (alu_sum)
	);

	// link RAM: pushes write the old head, alloc reads the head's link
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(idx_q);
		if (state_q == S_INIT_WALK) begin
			ram_we = 1'b1;
		end else if (state_q == S_FREE_CHK && free_ok) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(diff_q[pfla_pkg::BASE_W-1:0]);
		end
		ram_re    = in_fire && (req.kind == pfla_pkg::KIND_ALLOC);
		ram_raddr = AW'(head_q - LW'(1));
	end

	pfla_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_PAGES)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (head_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			pages_q     <= '0;
			head_q      <= '0;
			total_q     <= '0;
			addr_q      <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			off_q       <= '0;
			diff_q      <= '0;
			res_addr_q  <= '0;
			res_ok_q    <= 1'b0;
			res_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_addr_q  <= '0;
			out_ok_q    <= 1'b0;
			out_cnt_q   <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					pfla_pkg::REG_BASE:  base_q  <= cfg_data;
					pfla_pkg::REG_PAGES: pages_q <= cfg_data[pfla_pkg::CNT_W-1:0];
					default: ;
				endcase
			end

			// a handover in the done state refills the register instead
			if (rsp.valid && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						addr_q     <= req.page_address;
						res_addr_q <= '0;
						// only an alloc from an empty list fails up front
						res_ok_q   <= !(req.kind == pfla_pkg::KIND_ALLOC && head_q == '0);
						res_cnt_q  <= total_q;
						case (req.kind)
							pfla_pkg::KIND_INIT: begin
								n_q   <= usable;
								idx_q <= '0;
								state_q <= (usable == '0) ? S_INIT_SUM : S_INIT_WALK;
							end
							pfla_pkg::KIND_ALLOC: begin
								off_q <= head_q - LW'(1);
								if (head_q == '0) begin
									state_q  <= S_DONE;
								end else begin
									state_q <= S_ALLOC_POP;
								end
							end
							pfla_pkg::KIND_FREE: begin
								state_q <= S_FREE_SUB;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INIT_WALK: begin
					head_q <= LW'(idx_q) + LW'(1);
					idx_q  <= idx_q + pfla_pkg::CNT_W'(1);
					if (idx_q == n_q - pfla_pkg::CNT_W'(1)) begin
						state_q <= S_INIT_SUM;
					end
				end
				S_INIT_SUM: begin
					total_q   <= sat_sum;
					res_cnt_q <= n_q;
					state_q   <= S_DONE;
				end
				S_ALLOC_POP: begin
					head_q     <= ram_rdata;
					res_addr_q <= {alu_sum[pfla_pkg::BASE_W-1:0], pfla_pkg::PAGE_SHIFT'(0)};
					if (total_q != '0) begin
						total_q   <= total_q - pfla_pkg::CNT_W'(1);
						res_cnt_q <= total_q - pfla_pkg::CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_FREE_SUB: begin
					diff_q  <= alu_sum;
					state_q <= S_FREE_CHK;
				end
				S_FREE_CHK: begin
					if (free_ok) begin
						head_q    <= LW'(diff_q[pfla_pkg::BASE_W-1:0]) + LW'(1);
						total_q   <= sat_sum;
						res_cnt_q <= sat_sum;
					end else begin
						res_ok_q <= 1'b0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hand over once the result register is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= res_addr_q;
						out_ok_q    <= res_ok_q;
						out_cnt_q   <= res_cnt_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// an accepted item always leaves the idle state
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("sequencer idle after accepting an item");

	// link RAM is written only by a push
	a_write_only_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_INIT_WALK || state_q == S_FREE_CHK))
		else $error("link RAM written outside a push");

	// a finished item reaches the result register when it is free
	a_done_hands_over: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!out_valid_q || rsp.ready)) |=> out_valid_q)
		else $error("result not handed over");

	// an empty list never yields a successful alloc
	a_empty_alloc_fails: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && req.kind == pfla_pkg::KIND_ALLOC && head_q == '0) |=> !res_ok_q)
		else $error("alloc from an empty list succeeded");

endmodule
`default_nettype wire
